FILE: hdl/rotated_vertex_bounding_box_defines.svh
// assertion macros for the rotated vertex bounding box
`ifndef ROTATED_VERTEX_BOUNDING_BOX_DEFINES_SVH
`define ROTATED_VERTEX_BOUNDING_BOX_DEFINES_SVH

`ifndef SYNTHESIS

`define RVBB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define RVBB_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RVBB_ASSERT(name, clk, rst, prop, msg)

`define RVBB_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

FILE: hdl/rvbb_pkg.sv
// shared types and constants for the rotated vertex bounding box
package rvbb_pkg;

   localparam int COORD_W = 32;
   localparam int COEF_W  = 18;
   localparam int FRAC_W  = 16;
   localparam int ROW_W   = 3 * COEF_W;
   localparam int MUL_W   = COORD_W + COEF_W;
   localparam int PROD_W  = MUL_W - FRAC_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int HALF_W  = COORD_W - 1;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // register indexes
   localparam logic [1:0] REG_ROT_ROW0 = 2'd0;
   localparam logic [1:0] REG_ROT_ROW1 = 2'd1;
   localparam logic [1:0] REG_ROT_ROW2 = 2'd2;

   localparam logic [ROW_W-1:0] ROT_ROW0_RESET = ROW_W'(64'd65536);
   localparam logic [ROW_W-1:0] ROT_ROW1_RESET = ROW_W'(64'd17179869184);
   localparam logic [ROW_W-1:0] ROT_ROW2_RESET = ROW_W'(64'd4503599627370496);

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      has_vertex;
      logic      last;
   } vertex_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      has_vertex;
      logic      last;
   } point_type;

endpackage

FILE: hdl/rvbb_rotate.sv
// three-stage rotation pipeline: input register, nine products, saturated row sums
module rvbb_rotate import rvbb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vertex_type            in_item,
   input  logic [2:0][ROW_W-1:0] rot_rows,
   output logic                  out_valid,
   input  logic                  out_ready,
   output point_type             out_item
);

   logic v1_ff, v2_ff, v3_ff;
   logic r1, r2, r3;

   vertex_type s1_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic s2_has_ff, s2_last_ff;

   coord_type sat_in [3];
   point_type s3_ff;

   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
   end

   // stage 1: input register
   always_ff @(posedge clock) begin
      if (r1 && in_valid) s1_ff <= in_item;
   end

   // stage 2: coefficient times coordinate, floor to Q18.16
   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         logic signed [COEF_W-1:0]  coef;
         logic signed [COORD_W-1:0] coord;
         logic signed [MUL_W-1:0]   mul;
         assign coef  = $signed(rot_rows[r][c*COEF_W +: COEF_W]);
         assign coord = (c == 0) ? s1_ff.x : ((c == 1) ? s1_ff.y : s1_ff.z);
         assign mul   = MUL_W'(coef) * MUL_W'(coord);
         assign prod_in[r][c] = $signed(mul[MUL_W-1:FRAC_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (r2 && v1_ff) begin
         prod_ff    <= prod_in;
         s2_has_ff  <= s1_ff.has_vertex;
         s2_last_ff <= s1_ff.last;
      end
   end

   // stage 3: exact row sum, saturate to 32 bits
   for (genvar r = 0; r < 3; r++) begin : g_sum
      logic signed [SUM_W-1:0] sum;
      assign sum = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]) + SUM_W'(prod_ff[r][2]);
      always_comb begin
         if (sum > SUM_W'(COORD_MAX))      sat_in[r] = COORD_MAX;
         else if (sum < SUM_W'(COORD_MIN)) sat_in[r] = COORD_MIN;
         else                              sat_in[r] = sum[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (r3 && v2_ff) begin
         s3_ff.x          <= sat_in[0];
         s3_ff.y          <= sat_in[1];
         s3_ff.z          <= sat_in[2];
         s3_ff.has_vertex <= s2_has_ff;
         s3_ff.last       <= s2_last_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = s3_ff;

endmodule

FILE: hdl/rotated_vertex_bounding_box.sv
// top level: config registers, rotation pipeline, running min/max and result stage
//
// Streams one vertex per clock. Each item passes an input register, a product
// stage (nine 18x32 multipliers) and a saturating row-sum stage before the
// per-axis min/max update; an item with last set is then snapshotted and its
// centre and half extents are formed in the output register. The min/max
// update holds no stall of its own, so a new item is taken every cycle; input
// stalls only while a finished result waits in the output register, a second
// one in the snapshot stage and a third last item waits at the head of the
// rotation pipeline with the two stages behind it full.
// Rotation rows live at byte addresses 0, 8 and 16; the user must write them
// only while the block is idle, as the block itself does not enforce this.
`include "rotated_vertex_bounding_box_defines.svh"
module rotated_vertex_bounding_box import rvbb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_vertex_x,
   input  logic signed [31:0]      req_vertex_y,
   input  logic signed [31:0]      req_vertex_z,
   input  logic                    req_has_vertex,
   input  logic                    req_last,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_center_x,
   output logic signed [31:0]      rsp_center_y,
   output logic signed [31:0]      rsp_center_z,
   output logic [HALF_W-1:0]       rsp_half_x,
   output logic [HALF_W-1:0]       rsp_half_y,
   output logic [HALF_W-1:0]       rsp_half_z,
   output logic                    rsp_found,
   // configuration
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   logic [2:0][ROW_W-1:0] rot_ff;
   logic [1:0]            csr_index;

   vertex_type in_item;
   logic       in_ready;
   logic       rot_valid, rot_ready;
   point_type  rot_item;

   coord_type min_ff [3];
   coord_type max_ff [3];
   coord_type min_in [3];
   coord_type max_in [3];
   coord_type point [3];
   logic      seen_ff;

   logic      s4_valid_ff;
   coord_type s4_min_ff [3];
   coord_type s4_max_ff [3];
   logic      s4_seen_ff;
   logic      s4_ready;
   logic      out_ready;
   logic      acc_take;
   logic      close_box;

   logic              rsp_valid_ff;
   coord_type         center_ff [3];
   logic [HALF_W-1:0] half_ff [3];
   logic              found_ff;

   logic box_at_reset;
   logic box_ordered;
   logic empty_ok;

   // configuration port
   assign pready    = 1'b1;
   assign csr_index = paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROT_ROW0_RESET;
         rot_ff[1] <= ROT_ROW1_RESET;
         rot_ff[2] <= ROT_ROW2_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_index)
            REG_ROT_ROW0: rot_ff[0] <= pwdata[ROW_W-1:0];
            REG_ROT_ROW1: rot_ff[1] <= pwdata[ROW_W-1:0];
            REG_ROT_ROW2: rot_ff[2] <= pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROT_ROW0: prdata = CSR_DATA_W'(rot_ff[0]);
         REG_ROT_ROW1: prdata = CSR_DATA_W'(rot_ff[1]);
         REG_ROT_ROW2: prdata = CSR_DATA_W'(rot_ff[2]);
         default:      prdata = '0;
      endcase
   end

   // rotation pipeline
   assign in_item.x          = req_vertex_x;
   assign in_item.y          = req_vertex_y;
   assign in_item.z          = req_vertex_z;
   assign in_item.has_vertex = req_has_vertex;
   assign in_item.last       = req_last;
   assign req_stall          = !in_ready;

   rvbb_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_item   (in_item),
      .rot_rows  (rot_ff),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_item  (rot_item)
   );

   // only an item that closes a mesh needs room downstream
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign rot_ready = !rot_item.last || s4_ready;
   assign acc_take  = rot_valid && rot_ready;
   assign close_box = acc_take && rot_item.last;

   assign point[0] = rot_item.x;
   assign point[1] = rot_item.y;
   assign point[2] = rot_item.z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         min_in[i] = min_ff[i];
         max_in[i] = max_ff[i];
         if (rot_item.has_vertex) begin
            if (point[i] < min_ff[i]) min_in[i] = point[i];
            if (point[i] > max_ff[i]) max_in[i] = point[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= COORD_MAX;
            max_ff[i] <= COORD_MIN;
         end
         seen_ff <= 1'b0;
      end else if (acc_take) begin
         if (rot_item.last) begin
            for (int i = 0; i < 3; i++) begin
               min_ff[i] <= COORD_MAX;
               max_ff[i] <= COORD_MIN;
            end
            seen_ff <= 1'b0;
         end else begin
            min_ff  <= min_in;
            max_ff  <= max_in;
            seen_ff <= seen_ff || rot_item.has_vertex;
         end
      end
   end

   // snapshot of the closed box
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= close_box;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && close_box) begin
         s4_min_ff  <= min_in;
         s4_max_ff  <= max_in;
         s4_seen_ff <= seen_ff || rot_item.has_vertex;
      end
   end

   // result stage: floor halves of sum and difference, zeros when no vertex was seen
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_out
      logic signed [COORD_W:0] sum;
      logic signed [COORD_W:0] diff;
      assign sum  = (COORD_W+1)'(s4_max_ff[i]) + (COORD_W+1)'(s4_min_ff[i]);
      assign diff = (COORD_W+1)'(s4_max_ff[i]) - (COORD_W+1)'(s4_min_ff[i]);
      always_ff @(posedge clock) begin
         if (out_ready && s4_valid_ff) begin
            if (s4_seen_ff) begin
               center_ff[i] <= sum[COORD_W:1];
               half_ff[i]   <= diff[HALF_W:1];
            end else begin
               center_ff[i] <= '0;
               half_ff[i]   <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s4_valid_ff) found_ff <= s4_seen_ff;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_center_x = center_ff[0];
   assign rsp_center_y = center_ff[1];
   assign rsp_center_z = center_ff[2];
   assign rsp_half_x   = half_ff[0];
   assign rsp_half_y   = half_ff[1];
   assign rsp_half_z   = half_ff[2];
   assign rsp_found    = found_ff;

   assign box_at_reset = min_ff[0] == COORD_MAX && min_ff[1] == COORD_MAX &&
                         min_ff[2] == COORD_MAX && max_ff[0] == COORD_MIN &&
                         max_ff[1] == COORD_MIN && max_ff[2] == COORD_MIN;
   assign box_ordered  = min_ff[0] <= max_ff[0] && min_ff[1] <= max_ff[1] &&
                         min_ff[2] <= max_ff[2];
   assign empty_ok     = found_ff ||
                         (center_ff[0] == '0 && center_ff[1] == '0 && center_ff[2] == '0 &&
                          half_ff[0] == '0 && half_ff[1] == '0 && half_ff[2] == '0);

   `RVBB_ASSERT(a_last_reaches_snapshot, clock, reset, close_box |=> s4_valid_ff, "last item lost")
   `RVBB_ASSERT(a_box_cleared, clock, reset, !seen_ff |-> box_at_reset, "stale empty box")
   `RVBB_ASSERT(a_box_ordered, clock, reset, seen_ff |-> box_ordered, "minimum above maximum")
   `RVBB_ASSERT(a_empty_result_zero, clock, reset, rsp_valid_ff |-> empty_ok, "nonzero empty result")
   `RVBB_ASSERT(a_snapshot_held, clock, reset, !s4_ready |=> s4_valid_ff, "snapshot lost")

endmodule
